### hdl/gjl_pkg.sv
// gjl_pkg: shared types, codes and font gap tables for the glyph layout block
// no dependencies; used by gjl_front, gjl_back and the top module in hdl/
package gjl_pkg;

  localparam logic [1:0] KIND_HALF   = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  localparam logic [1:0] CFG_RIGHT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_LINE_PITCH  = 2'd1;

  localparam logic [9:0] RIGHT_LIMIT_RESET = 10'd480;
  localparam logic [5:0] LINE_PITCH_RESET  = 6'd10;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [9:0] Y_MAX = 10'h3FF;

  localparam int NUM_GAPS = 18;

  // gap ranges of the full-width font, ascending and disjoint
  localparam logic [15:0] GAP_START [NUM_GAPS] = '{
    16'hA2AF, 16'hA2C2, 16'hA2D1, 16'hA2EB, 16'hA2FA, 16'hA3A1, 16'hA3BA, 16'hA3DB, 16'hA3FB,
    16'hA4F4, 16'hA5F7, 16'hA6B9, 16'hA6D9, 16'hA7C2, 16'hA7F2, 16'hA8C1, 16'hCFD4, 16'hF4A5
  };
  localparam logic [15:0] GAP_END [NUM_GAPS] = '{
    16'hA2B9, 16'hA2C9, 16'hA2DB, 16'hA2F1, 16'hA2FD, 16'hA3AF, 16'hA3C0, 16'hA3E0, 16'hA3FE,
    16'hA4FE, 16'hA5FE, 16'hA6C0, 16'hA6FE, 16'hA7D0, 16'hA7FE, 16'hAB90, 16'hCFFE, 16'hF8AA
  };
  // running total of gap lengths up to and including each gap
  localparam logic [15:0] GAP_SUB [NUM_GAPS] = '{
    16'd11, 16'd19, 16'd30, 16'd37, 16'd41, 16'd56, 16'd63, 16'd69, 16'd73,
    16'd84, 16'd92, 16'd100, 16'd138, 16'd153, 16'd166, 16'd886, 16'd929, 16'd1959
  };

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        first;
    logic [9:0]  start_x;
    logic [9:0]  start_y;
    logic [15:0] color;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  glyph_kind;
    logic [10:0] pos_x;
    logic [9:0]  pos_y;
    logic [15:0] glyph_index;
    logic        missing;
    logic [15:0] draw_color;
  } out_item_t;

  // draw command from the cursor front end to the index back end
  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] pos_x;
    logic [9:0]  pos_y;
    logic [7:0]  lead;
    logic [7:0]  ch;
    logic [15:0] color;
  } cmd_t;

endpackage

### hdl/gjl_fifo.sv
// gjl_fifo: small flop-based first-in first-out queue
// generic payload vector; no package dependencies
module gjl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

### hdl/gjl_front.sv
// gjl_front: cursor, mode and lead-byte tracking; emits one draw command per glyph
// depends on gjl_pkg
module gjl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  gjl_pkg::in_item_t  item,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  output logic               cmd_valid,
  output gjl_pkg::cmd_t      cmd
);

  logic [10:0] cursor_x;
  logic [9:0]  cursor_y;
  logic [9:0]  line_start_x;
  logic [7:0]  lead_byte;
  logic        double_mode;
  logic        stopped;
  logic [9:0]  right_limit;
  logic [5:0]  line_pitch;

  logic [10:0] cursor_x_next;
  logic [9:0]  cursor_y_next;
  logic [9:0]  line_start_x_next;
  logic [7:0]  lead_byte_next;
  logic        double_mode_next;
  logic        stopped_next;

  logic        accept;
  logic        emit;
  logic [1:0]  kind;
  logic [10:0] y_sum;
  logic [7:0]  ch;

  assign accept = push && !full;
  assign ch     = item.text_byte;

  always_comb begin
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    line_start_x_next = line_start_x;
    lead_byte_next    = lead_byte;
    double_mode_next  = double_mode;
    stopped_next      = stopped;
    emit              = 1'b0;
    kind              = gjl_pkg::KIND_HALF;
    y_sum             = '0;

    if (item.first) begin
      cursor_x_next     = {1'b0, item.start_x};
      line_start_x_next = item.start_x;
      cursor_y_next     = item.start_y;
      lead_byte_next    = '0;
      double_mode_next  = 1'b0;
      stopped_next      = 1'b0;
    end

    // position of the glyph is the cursor before the advance
    cmd.pos_x = cursor_x_next;
    cmd.pos_y = cursor_y_next;
    cmd.lead  = lead_byte_next;
    cmd.ch    = ch;
    cmd.color = item.color;

    if (!stopped_next) begin
      if (ch == gjl_pkg::CH_NUL) begin
        stopped_next   = 1'b1;
        lead_byte_next = '0;
      end else begin
        if (lead_byte_next != '0) begin
          kind           = gjl_pkg::KIND_FULL;
          emit           = 1'b1;
          lead_byte_next = '0;
        end else if (ch[7] && (ch[6] == ch[5])) begin
          // 0x80..0x9f or 0xe0..0xff opens a double-byte character
          lead_byte_next = ch;
        end else if (ch == gjl_pkg::CH_NEWLINE) begin
          cursor_x_next = {1'b0, line_start_x_next};
          y_sum         = {1'b0, cursor_y_next} + {5'b0, line_pitch};
          cursor_y_next = (y_sum > {1'b0, gjl_pkg::Y_MAX}) ? gjl_pkg::Y_MAX : y_sum[9:0];
        end else if (ch == gjl_pkg::CH_TAB) begin
          double_mode_next = !double_mode_next;
        end else if (double_mode_next) begin
          kind = gjl_pkg::KIND_DOUBLE;
          emit = 1'b1;
        end else begin
          kind = gjl_pkg::KIND_HALF;
          emit = 1'b1;
        end

        if (emit) begin
          case (kind)
            gjl_pkg::KIND_FULL:   cursor_x_next = cursor_x_next + 11'd10;
            gjl_pkg::KIND_DOUBLE: cursor_x_next = cursor_x_next + 11'd16;
            default:              cursor_x_next = cursor_x_next + 11'd5;
          endcase
        end
        if (cursor_x_next >= {1'b0, right_limit}) begin
          stopped_next = 1'b1;
        end
      end
    end

    cmd.kind  = kind;
    cmd_valid = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      line_start_x <= '0;
      lead_byte    <= '0;
      double_mode  <= 1'b0;
      stopped      <= 1'b1;
      right_limit  <= gjl_pkg::RIGHT_LIMIT_RESET;
      line_pitch   <= gjl_pkg::LINE_PITCH_RESET;
    end else begin
      if (accept) begin
        cursor_x     <= cursor_x_next;
        cursor_y     <= cursor_y_next;
        line_start_x <= line_start_x_next;
        lead_byte    <= lead_byte_next;
        double_mode  <= double_mode_next;
        stopped      <= stopped_next;
      end
      if (cfg_valid) begin
        case (cfg_index)
          gjl_pkg::CFG_RIGHT_LIMIT: right_limit <= cfg_data;
          gjl_pkg::CFG_LINE_PITCH:  line_pitch  <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  a_nul_stops: assert property (@(posedge clk) disable iff (rst)
    (accept && (ch == gjl_pkg::CH_NUL)) |=> stopped)
    else $error("zero byte did not stop the string");

  a_emit_needs_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (accept && !stopped_next) || (accept && kind != gjl_pkg::KIND_HALF) ||
                  (accept && ch != gjl_pkg::CH_NUL))
    else $error("draw command without an accepted byte");

endmodule

### hdl/gjl_back.sv
// gjl_back: glyph index pipeline, code conversion then gap compare and subtract
// depends on gjl_pkg; reads the command queue and fills the result queue
module gjl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  gjl_pkg::cmd_t      q_data,
  output logic               q_pop,
  input  logic               o_full,
  output logic               o_wr,
  output gjl_pkg::out_item_t o_data
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] pos_x;
    logic [9:0]  pos_y;
    logic [15:0] color;
    logic [15:0] code;
  } s1_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] pos_x;
    logic [9:0]  pos_y;
    logic [15:0] color;
    logic [15:0] n_raw;
    logic [15:0] sub;
    logic        miss;
  } s2_t;

  s1_t  s1;
  s2_t  s2;
  s1_t  s1_next;
  s2_t  s2_next;
  logic s1_valid;
  logic s2_valid;
  logic s1_ready;
  logic s2_ready;

  logic [15:0] code0;
  logic [15:0] conv;
  logic [7:0]  lo;
  logic [7:0]  lo2;
  logic [7:0]  hi_m;
  logic [15:0] half_idx;
  logic [15:0] row;

  assign s2_ready = !s2_valid || !o_full;
  assign s1_ready = !s1_valid || s2_ready;
  assign q_pop    = !q_empty && s1_ready;
  assign o_wr     = s2_valid && !o_full;

  // stage 1: shift-jis pair to euc, or the single-byte index
  always_comb begin
    code0 = {q_data.lead, q_data.ch};
    if (code0 >= 16'hE000) begin
      code0 = code0 - 16'h4000;
    end
    lo   = code0[7:0];
    hi_m = code0[15:8] - 8'h81;
    conv = {hi_m[6:0], 9'b0} + {8'b0, lo};
    lo2  = lo;
    if (lo >= 8'h80) begin
      conv = conv - 16'd1;
      lo2  = lo - 8'd1;
    end
    if (lo2 >= 8'h9E) begin
      conv = conv + 16'h0062;
    end else begin
      conv = conv - 16'h0040;
    end
    conv = conv + 16'h2121 + 16'h8080;

    if (q_data.ch < 8'h20) begin
      half_idx = '0;
    end else if (q_data.ch < 8'h80) begin
      half_idx = {8'b0, q_data.ch - 8'h20};
    end else if (q_data.ch < 8'hA0) begin
      half_idx = '0;
    end else begin
      half_idx = {8'b0, q_data.ch - 8'h40};
    end

    s1_next.kind  = q_data.kind;
    s1_next.pos_x = q_data.pos_x;
    s1_next.pos_y = q_data.pos_y;
    s1_next.color = q_data.color;
    case (q_data.kind)
      gjl_pkg::KIND_FULL:   s1_next.code = conv;
      gjl_pkg::KIND_DOUBLE: s1_next.code = {8'b0, q_data.ch};
      default:              s1_next.code = half_idx;
    endcase
  end

  // stage 2: dense row index and gap lookup; the hit gap is the highest one started
  always_comb begin
    s2_next.kind  = s1.kind;
    s2_next.pos_x = s1.pos_x;
    s2_next.pos_y = s1.pos_y;
    s2_next.color = s1.color;
    s2_next.n_raw = s1.code;
    s2_next.sub   = '0;
    s2_next.miss  = 1'b0;
    row           = {8'b0, s1.code[15:8]} - 16'h00A1;
    if (s1.kind == gjl_pkg::KIND_FULL) begin
      s2_next.n_raw = 16'(row * 16'd94) + {8'b0, s1.code[7:0]} - 16'h00A1;
      for (int i = 0; i < gjl_pkg::NUM_GAPS; i++) begin
        if (s1.code >= gjl_pkg::GAP_START[i]) begin
          s2_next.sub  = gjl_pkg::GAP_SUB[i];
          s2_next.miss = (s1.code <= gjl_pkg::GAP_END[i]);
        end
      end
    end
  end

  always_comb begin
    o_data.glyph_kind  = s2.kind;
    o_data.pos_x       = s2.pos_x;
    o_data.pos_y       = s2.pos_y;
    o_data.glyph_index = s2.miss ? 16'd0 : (s2.n_raw - s2.sub);
    o_data.missing     = s2.miss;
    o_data.draw_color  = s2.color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= !q_empty;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= s1_next;
    end
    if (s2_ready && s1_valid) begin
      s2 <= s2_next;
    end
  end

  a_miss_full_zero: assert property (@(posedge clk) disable iff (rst)
    (o_wr && o_data.missing) |->
      (o_data.glyph_kind == gjl_pkg::KIND_FULL) && (o_data.glyph_index == 16'd0))
    else $error("missing glyph on a non full-width command or with nonzero index");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && o_full) |=> s2_valid && $stable(s2))
    else $error("stage 2 lost its command while stalled");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> s1_valid && $stable(s1))
    else $error("stage 1 lost its command while stalled");

endmodule

### hdl/mixed_width_text_glyph_layout_top.sv
// mixed-width text glyph layout: one byte a transaction, one draw command per glyph
// path: a draw command passes the command queue, stage 1, stage 2 and the result queue
// throughput: one byte per cycle while the command queue is not full, set by the cursor update
// the back end index pipeline (conversion, gap compare) sustains one command per cycle unless the result queue is full
// reset: synchronous; cursor and mode cleared, string stopped, registers to 480 and 10
// depends on gjl_pkg, gjl_front, gjl_back, gjl_fifo
module mixed_width_text_glyph_layout_top #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  gjl_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output gjl_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  logic               cmd_valid;
  gjl_pkg::cmd_t      cmd;
  logic               mid_empty;
  logic               mid_pop;
  gjl_pkg::cmd_t      mid_data;
  logic               out_full;
  logic               out_wr;
  gjl_pkg::out_item_t out_data;

  assign cfg_ready = 1'b1;

  gjl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  gjl_fifo #(
    .WIDTH ($bits(gjl_pkg::cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .full    (full),
    .rd_en   (mid_pop),
    .rd_data (mid_data),
    .empty   (mid_empty)
  );

  gjl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (mid_empty),
    .q_data  (mid_data),
    .q_pop   (mid_pop),
    .o_full  (out_full),
    .o_wr    (out_wr),
    .o_data  (out_data)
  );

  gjl_fifo #(
    .WIDTH ($bits(gjl_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (out_data),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

### tb/sv/mixed_width_text_glyph_layout_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench for mixed_width_text_glyph_layout_top: byte strings in, draw commands out
// cursor and glyph index prediction is done inline; depends on gjl_pkg and the block's rtl
module mixed_width_text_glyph_layout_top_test;

  localparam int SETTLE_CYCLES = 6;
  localparam int RUN_LIMIT = 400000;

  // holes in the full-width font: first euc code and length of each
  localparam logic [15:0] FONT_HOLE_AT [gjl_pkg::NUM_GAPS] = '{
    16'hA2AF, 16'hA2C2, 16'hA2D1, 16'hA2EB, 16'hA2FA, 16'hA3A1, 16'hA3BA, 16'hA3DB, 16'hA3FB,
    16'hA4F4, 16'hA5F7, 16'hA6B9, 16'hA6D9, 16'hA7C2, 16'hA7F2, 16'hA8C1, 16'hCFD4, 16'hF4A5
  };
  localparam logic [15:0] FONT_HOLE_LEN [gjl_pkg::NUM_GAPS] = '{
    16'd11, 16'd8, 16'd11, 16'd7, 16'd4, 16'd15, 16'd7, 16'd6, 16'd4,
    16'd11, 16'd8, 16'd8, 16'd38, 16'd15, 16'd13, 16'd720, 16'd43, 16'd1030
  };

  typedef enum logic [1:0] {SEND_BYTE, WRITE_REG, WAIT_IDLE} text_op_kind_t;

  typedef struct {
    text_op_kind_t      kind;
    gjl_pkg::in_item_t  bytes;
    logic [1:0]         reg_sel;
    logic [9:0]         reg_val;
  } text_op_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  gjl_pkg::in_item_t  item = '0;
  logic               empty;
  logic               pop = 1'b0;
  gjl_pkg::out_item_t result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = gjl_pkg::CFG_RIGHT_LIMIT;
  logic [9:0]         cfg_data = '0;

  text_op_t           script [$];
  gjl_pkg::out_item_t draw_cmds_due [$];
  int                 bad_cmds = 0;
  int                 cycles = 0;
  int                 rest_left = 0;
  int                 hold_left = 0;
  int                 send_calm = 0;
  int                 take_calm = 0;
  int                 idle_run = 0;

  // layout state as the block should hold it
  logic [10:0] cur_x = '0;
  logic [9:0]  cur_y = '0;
  logic [9:0]  margin_x = '0;
  logic [7:0]  lead = '0;
  bit          dbl_size = 1'b0;
  bit          halted = 1'b1;
  logic [9:0]  limit_x = gjl_pkg::RIGHT_LIMIT_RESET;
  logic [5:0]  pitch_y = gjl_pkg::LINE_PITCH_RESET;

  mixed_width_text_glyph_layout_top DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // shift-jis pair to euc, then to a dense font index with the holes squeezed out
  function automatic logic [15:0] sjis_glyph(input logic [7:0] hi, input logic [7:0] lo,
                                             output logic hole);
    logic [15:0] code;
    logic [15:0] row;
    logic [15:0] n;
    logic [15:0] hole_end;
    code = {hi, lo};
    if (code >= 16'hE000) code = code - 16'h4000;
    row = {8'h00, code[15:8]} - 16'h0081;
    code = (row << 9) + {8'h00, code[7:0]};
    if (code[7:0] >= 8'h80) code = code - 16'd1;
    if (code[7:0] >= 8'h9E) code = code + 16'h0062;
    else code = code - 16'h0040;
    code = code + 16'hA1A1;
    n = ({8'h00, code[15:8]} - 16'h00A1) * 16'd94 + {8'h00, code[7:0]} - 16'h00A1;
    hole = 1'b0;
    for (int i = 0; i < gjl_pkg::NUM_GAPS; i++) begin
      if (code >= FONT_HOLE_AT[i]) begin
        hole_end = FONT_HOLE_AT[i] + FONT_HOLE_LEN[i] - 16'd1;
        if (code <= hole_end) begin
          hole = 1'b1;
          return 16'h0000;
        end
        n = n - FONT_HOLE_LEN[i];
      end
    end
    return n;
  endfunction

  // advances the layout state by one byte; returns 1 when a draw command results
  function automatic bit layout_byte(input gjl_pkg::in_item_t it,
                                     output gjl_pkg::out_item_t cmd);
    logic [7:0]  ch;
    logic [15:0] idx;
    logic [1:0]  kind;
    logic        hole;
    bit          emit;
    int          y_next;
    ch = it.text_byte;
    idx = '0;
    kind = gjl_pkg::KIND_HALF;
    hole = 1'b0;
    emit = 1'b0;
    cmd = '0;
    if (it.first) begin
      cur_x = {1'b0, it.start_x};
      margin_x = it.start_x;
      cur_y = it.start_y;
      lead = '0;
      dbl_size = 1'b0;
      halted = 1'b0;
    end
    if (halted) return 1'b0;
    if (ch == gjl_pkg::CH_NUL) begin
      halted = 1'b1;
      lead = '0;
      return 1'b0;
    end
    if (lead != 8'h00) begin
      kind = gjl_pkg::KIND_FULL;
      idx = sjis_glyph(lead, ch, hole);
      emit = 1'b1;
      lead = '0;
    end else if ((ch >= 8'h80 && ch < 8'hA0) || ch >= 8'hE0) begin
      lead = ch;
    end else if (ch == gjl_pkg::CH_NEWLINE) begin
      cur_x = {1'b0, margin_x};
      y_next = int'(cur_y) + int'(pitch_y);
      cur_y = (y_next > int'(gjl_pkg::Y_MAX)) ? gjl_pkg::Y_MAX : y_next[9:0];
    end else if (ch == gjl_pkg::CH_TAB) begin
      dbl_size = ~dbl_size;
    end else if (dbl_size) begin
      kind = gjl_pkg::KIND_DOUBLE;
      idx = {8'h00, ch};
      emit = 1'b1;
    end else begin
      kind = gjl_pkg::KIND_HALF;
      if (ch < 8'h20) idx = '0;
      else if (ch < 8'h80) idx = {8'h00, ch - 8'h20};
      else idx = {8'h00, ch - 8'h40};
      emit = 1'b1;
    end
    if (emit) begin
      cmd.glyph_kind = kind;
      cmd.pos_x = cur_x;
      cmd.pos_y = cur_y;
      cmd.glyph_index = idx;
      cmd.missing = hole;
      cmd.draw_color = it.color;
      if (kind == gjl_pkg::KIND_FULL) cur_x = cur_x + 11'd10;
      else if (kind == gjl_pkg::KIND_DOUBLE) cur_x = cur_x + 11'd16;
      else cur_x = cur_x + 11'd5;
    end
    if (cur_x >= {1'b0, limit_x}) halted = 1'b1;
    return emit;
  endfunction

  // mostly no gap, often a short one, a few long ones, and now and then a stretch with none
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 185) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic string describe(input gjl_pkg::out_item_t c);
    return $sformatf("kind %0d x %0d y %0d index %h missing %0b color %h",
                     c.glyph_kind, c.pos_x, c.pos_y, c.glyph_index, c.missing, c.draw_color);
  endfunction

  task automatic queue_byte(input bit fb, input logic [9:0] sx, input logic [9:0] sy,
                            input logic [7:0] b, input logic [15:0] ink);
    text_op_t op;
    op.kind = SEND_BYTE;
    op.bytes.text_byte = b;
    op.bytes.first = fb;
    op.bytes.start_x = sx;
    op.bytes.start_y = sy;
    op.bytes.color = ink;
    op.reg_sel = gjl_pkg::CFG_RIGHT_LIMIT;
    op.reg_val = '0;
    script.push_back(op);
  endtask

  task automatic queue_reg(input logic [1:0] sel, input logic [9:0] val);
    text_op_t op;
    op.kind = WRITE_REG;
    op.bytes = '0;
    op.reg_sel = sel;
    op.reg_val = val;
    script.push_back(op);
  endtask

  // one character: a single byte or a lead/trail pair
  function automatic int pick_char(output logic [7:0] c0, output logic [7:0] c1);
    int r;
    r = $urandom_range(0, 99);
    c1 = 8'h00;
    if (r < 28) begin
      c0 = 8'($urandom_range(8'h20, 8'h7E));
      return 1;
    end
    if (r < 42) begin
      c0 = 8'($urandom_range(8'hA0, 8'hDF));
      return 1;
    end
    if (r < 74) begin
      c0 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hE0, 8'hFF)) :
                                          8'($urandom_range(8'h80, 8'h9F));
      c1 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) :
                                          8'($urandom_range(8'h40, 8'hFC));
      return 2;
    end
    if (r < 81) c0 = gjl_pkg::CH_NEWLINE;
    else if (r < 88) c0 = gjl_pkg::CH_TAB;
    else if (r < 93) c0 = 8'($urandom_range(1, 8'h1F));
    else c0 = 8'($urandom_range(1, 255));
    return 1;
  endfunction

  // a well-formed string: start position on the first byte, mostly ended by a zero
  task automatic add_string(inout int budget);
    logic [7:0]  b [$];
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [15:0] ink;
    logic [9:0]  sx;
    logic [9:0]  sy;
    int          len;
    ink = 16'($urandom);
    sx = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) :
                                       10'($urandom_range(0, 240));
    sy = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) :
                                       10'($urandom_range(0, 700));
    len = $urandom_range(1, 24);
    while (b.size() < len) begin
      if (pick_char(c0, c1) == 2) begin
        b.push_back(c0);
        b.push_back(c1);
      end else begin
        b.push_back(c0);
      end
    end
    if ($urandom_range(0, 7) != 0) b.push_back(gjl_pkg::CH_NUL);
    foreach (b[k]) begin
      if ($urandom_range(0, 15) == 0) ink = 16'($urandom);
      queue_byte(k == 0, sx, sy, b[k], ink);
    end
    budget -= b.size();
  endtask

  // raw bytes with random restarts, zeros and positions
  task automatic add_noise(inout int budget);
    logic [7:0] b;
    int         n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      b = 8'($urandom);
      if ($urandom_range(0, 5) == 0) b = gjl_pkg::CH_NUL;
      queue_byte($urandom_range(0, 3) == 0, 10'($urandom_range(0, 1023)),
                 10'($urandom_range(0, 1023)), b, 16'($urandom));
    end
    budget -= n;
  endtask

  task automatic add_phase(input logic [9:0] limit, input logic [9:0] pitch, input int budget,
                           input bit pause);
    text_op_t hold;
    queue_reg(gjl_pkg::CFG_RIGHT_LIMIT, limit);
    queue_reg(gjl_pkg::CFG_LINE_PITCH, pitch);
    while (budget > 0) begin
      if (pause && budget < 75) begin
        hold.kind = WAIT_IDLE;
        hold.bytes = '0;
        hold.reg_sel = gjl_pkg::CFG_RIGHT_LIMIT;
        hold.reg_val = '0;
        script.push_back(hold);
        pause = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) add_noise(budget);
      else add_string(budget);
    end
  endtask

  // sender: byte transactions and register writes, in script order
  always @(posedge clk) begin : driver
    gjl_pkg::out_item_t cmd;
    bit                 want_push;
    bit                 want_reg;
    want_push = 1'b0;
    want_reg = 1'b0;
    if (rst) begin
      push <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (push && !full) begin
        if (layout_byte(item, cmd)) draw_cmds_due.push_back(cmd);
        void'(script.pop_front());
        rest_left = pick_idle(send_calm);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gjl_pkg::CFG_RIGHT_LIMIT: limit_x = cfg_data;
          gjl_pkg::CFG_LINE_PITCH:  pitch_y = cfg_data[5:0];
          default: ;
        endcase
        void'(script.pop_front());
        idle_run = 0;
      end
      if (rest_left > 0) begin
        rest_left--;
      end else if (script.size() > 0) begin
        if (script[0].kind == SEND_BYTE) begin
          want_push = 1'b1;
        end else if (draw_cmds_due.size() != 0) begin
          idle_run = 0;
        end else if (idle_run < SETTLE_CYCLES) begin
          // bytes that draw nothing may still be in flight
          idle_run++;
        end else if (script[0].kind == WAIT_IDLE) begin
          void'(script.pop_front());
          idle_run = 0;
        end else begin
          want_reg = 1'b1;
        end
      end
      push <= want_push;
      if (want_push) item <= script[0].bytes;
      cfg_valid <= want_reg;
      if (want_reg) begin
        cfg_index <= script[0].reg_sel;
        cfg_data <= script[0].reg_val;
      end
    end
  end

  // receiver: random stalls, each draw command checked against the oldest one due
  always @(posedge clk) begin : monitor
    gjl_pkg::out_item_t want;
    bit                 wrong;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (draw_cmds_due.size() == 0) begin
          bad_cmds++;
          if (bad_cmds <= 10) $display("draw command with none due: %s", describe(result));
        end else begin
          want = draw_cmds_due.pop_front();
          wrong = (result.glyph_kind !== want.glyph_kind) || (result.pos_x !== want.pos_x) ||
                  (result.pos_y !== want.pos_y) || (result.glyph_index !== want.glyph_index) ||
                  (result.missing !== want.missing) || (result.draw_color !== want.draw_color);
          if (wrong) begin
            bad_cmds++;
            if (bad_cmds <= 10)
              $display("draw command mismatch\n  expected %s\n  actual   %s",
                       describe(want), describe(result));
          end
        end
        hold_left = pick_idle(take_calm);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("mixed_width_text_glyph_layout_top verification failed");
      $finish;
    end
  end

  initial begin
    // reset-value registers: every kind of glyph, tab and newline
    queue_byte(1'b1, 10'd0, 10'd0, 8'h20, 16'h0000);
    queue_byte(1'b0, 10'd0, 10'd0, 8'h7F, 16'hFFFF);
    queue_byte(1'b0, 10'd0, 10'd0, 8'h05, 16'h5A5A);
    queue_byte(1'b0, 10'd0, 10'd0, 8'hDF, 16'hA5A5);
    queue_byte(1'b0, 10'd0, 10'd0, 8'h81, 16'h1234);
    queue_byte(1'b0, 10'd0, 10'd0, 8'h40, 16'h1234);
    queue_byte(1'b0, 10'd0, 10'd0, 8'h81, 16'h8001);  // lands in the first font hole
    queue_byte(1'b0, 10'd0, 10'd0, 8'hAD, 16'h8001);
    queue_byte(1'b0, 10'd0, 10'd0, gjl_pkg::CH_TAB, 16'h0F0F);
    queue_byte(1'b0, 10'd0, 10'd0, 8'h41, 16'h0F0F);
    queue_byte(1'b0, 10'd0, 10'd0, 8'h01, 16'hF0F0);
    queue_byte(1'b0, 10'd0, 10'd0, gjl_pkg::CH_TAB, 16'hF0F0);
    queue_byte(1'b0, 10'd0, 10'd0, gjl_pkg::CH_NEWLINE, 16'h00FF);
    queue_byte(1'b0, 10'd0, 10'd0, 8'hFF, 16'hFF00);
    queue_byte(1'b0, 10'd0, 10'd0, 8'hFF, 16'hFF00);
    // lead byte dropped by the terminator, then a byte while stopped
    queue_byte(1'b0, 10'd0, 10'd0, 8'hE0, 16'h7777);
    queue_byte(1'b0, 10'd0, 10'd0, gjl_pkg::CH_NUL, 16'h7777);
    queue_byte(1'b0, 10'd0, 10'd0, 8'h41, 16'h7777);
    // start already past the right limit still draws its first byte
    queue_byte(1'b1, 10'd1023, 10'd1023, 8'h41, 16'hFFFF);
    // newline byte taken as a trail
    queue_byte(1'b1, 10'h155, 10'h2AA, 8'h9F, 16'hC3C3);
    queue_byte(1'b0, 10'h155, 10'h2AA, gjl_pkg::CH_NEWLINE, 16'hC3C3);
    queue_byte(1'b0, 10'h155, 10'h2AA, gjl_pkg::CH_NUL, 16'hC3C3);
    // widest limit and pitch: y saturates, a double glyph runs past the limit
    queue_reg(gjl_pkg::CFG_RIGHT_LIMIT, 10'd1023);
    queue_reg(gjl_pkg::CFG_LINE_PITCH, 10'd63);
    queue_byte(1'b1, 10'd1010, 10'd1000, gjl_pkg::CH_NEWLINE, 16'h3C3C);
    queue_byte(1'b0, 10'd1010, 10'd1000, 8'h41, 16'h3C3C);
    queue_byte(1'b0, 10'd1010, 10'd1000, gjl_pkg::CH_TAB, 16'h3C3C);
    queue_byte(1'b0, 10'd1010, 10'd1000, 8'h42, 16'h3C3C);

    add_phase(10'd1, 10'd1, 40, 1'b0);
    add_phase(10'd1023, 10'd63, 130, 1'b0);
    add_phase(10'($urandom_range(200, 1023)), 10'($urandom_range(1, 63)), 130, 1'b0);
    add_phase(gjl_pkg::RIGHT_LIMIT_RESET, 10'(gjl_pkg::LINE_PITCH_RESET), 130, 1'b1);
    add_phase(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 63)), 100, 1'b0);
    add_phase(10'd1023, 10'd1, 130, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (script.size() != 0 || push || cfg_valid || draw_cmds_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (bad_cmds == 0 && draw_cmds_due.size() == 0 && empty) begin
      $display("mixed_width_text_glyph_layout_top verification clean");
    end else begin
      $display("mixed_width_text_glyph_layout_top verification failed");
    end
    $finish;
  end

endmodule
